// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication on a clock with an active-high reset
`define ASSERT_SAME(lbl, clk, rst, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error(msg);

// next-cycle implication on a clock with an active-high reset
`define ASSERT_NEXT(lbl, clk, rst, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/jse_pkg.sv =====
// shared types, constants and helper functions of the json string escaper
`timescale 1ns / 1ps
`default_nettype none
package jse_pkg;

  localparam int unsigned SEQ_MAX = 12;
  localparam logic [15:0] CAPACITY_MAX = 16'hffff;
  localparam logic [15:0] CAPACITY_RESET = 16'd256;

  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_U = 8'h75;

  localparam logic [20:0] CP_LIMIT = 21'h10ffff;
  localparam logic [20:0] SURR_LO = 21'h00d800;
  localparam logic [20:0] SURR_HI = 21'h00dfff;
  localparam logic [20:0] CP_PLANE1 = 21'h010000;
  localparam logic [15:0] HI_BASE = 16'hd800;
  localparam logic [15:0] LO_BASE = 16'hdc00;

  // one decoded item: the bytes it writes, index 0 goes out first
  typedef struct packed {
    logic [SEQ_MAX-1:0][7:0] bytes;
    logic [3:0] len;
    logic [15:0] base;
    logic done;
    logic [15:0] length;
  } seq_t;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) r = 8'h30 + {4'b0, n};
    else r = 8'h57 + {4'b0, n};
    return r;
  endfunction

  // \uXXXX with lowercase hex digits
  function automatic logic [5:0][7:0] u16_esc(input logic [15:0] v);
    logic [5:0][7:0] s;
    s[0] = CH_BSLASH;
    s[1] = CH_U;
    s[2] = hex_char(v[15:12]);
    s[3] = hex_char(v[11:8]);
    s[4] = hex_char(v[7:4]);
    s[5] = hex_char(v[3:0]);
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== design/json_string_escaper_utf8.sv =====
// top level of the json string escaper with utf-8 to \u conversion
`timescale 1ns / 1ps
`default_nettype none
// Takes one raw string byte per item on the s_ side and sends the bytes it adds to a JSON
// output buffer on the m_ side, one result per byte, with tlast on the last result of each
// item and tuser set on the terminator that a zero byte writes. Plain text, in which each
// byte writes at most one result, streams at one byte per clock while m_tready is high; an
// item whose escape writes more than one byte (two for a named escape, six for \uXXXX,
// twelve for a surrogate pair) holds the input until its last byte is taken, as the
// output stage sends one byte per cycle while m_tready is high. Items that write nothing
// wait for a free output stage. An item's first result appears once the input register
// and the output stage have taken it. The user must write capacity on the cfg_ port only
// while the block is idle; the block does not enforce it. Zero acts as one.
module json_string_escaper_utf8 (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // in_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // out_byte, out_index, out_length
  output logic             m_tlast,   // run_last
  output logic [0:0]       m_tuser,   // string_done
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data   // out_capacity
);
  import jse_pkg::*;

  logic [15:0] out_capacity;
  logic        a_valid;
  logic [7:0]  a_byte;
  logic        take;
  logic        can_load;
  seq_t        seq;

  assign cfg_ready = 1'b1;
  assign take = a_valid && can_load;
  assign s_tready = !a_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      out_capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      a_valid <= 1'b1;
      a_byte <= s_tdata;
    end else if (take) begin
      a_valid <= 1'b0;
    end
  end

  jse_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .in_byte      (a_byte),
    .out_capacity (out_capacity),
    .seq          (seq)
  );

  jse_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (take && seq.len != 4'd0),
    .seq      (seq),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
`default_nettype wire

// ===== design/jse_decode.sv =====
// string state and per-byte escape decode
`timescale 1ns / 1ps
`default_nettype none
module jse_decode (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          take,
  input  wire logic [7:0]    in_byte,
  input  wire logic [15:0]   out_capacity,
  output jse_pkg::seq_t      seq
);
  import jse_pkg::*;

  logic [15:0] used_count, used_count_next;
  logic        halted, halted_next;
  logic [20:0] code_accum, code_accum_next;
  logic [1:0]  pending_cont, pending_cont_next;

  logic [15:0] cap;
  logic        fresh;
  logic        code_ev;
  logic [20:0] cp;
  logic [20:0] acc_cat;
  logic [19:0] off;
  logic [7:0]  named;
  logic        named_ev;
  logic [3:0]  esc_len;
  logic [SEQ_MAX-1:0][7:0] esc_bytes;

  always_comb begin
    if (out_capacity == 16'd0) cap = 16'd1;
    else if (out_capacity > CAPACITY_MAX) cap = CAPACITY_MAX;
    else cap = out_capacity;
  end

  always_comb begin
    case (in_byte)
      8'h22:   named = 8'h22;
      8'h5c:   named = 8'h5c;
      8'h08:   named = 8'h62;
      8'h0c:   named = 8'h66;
      8'h0a:   named = 8'h6e;
      8'h0d:   named = 8'h72;
      8'h09:   named = 8'h74;
      default: named = 8'h00;
    endcase
  end

  always_comb begin
    seq = '0;
    used_count_next = used_count;
    halted_next = halted;
    code_accum_next = code_accum;
    pending_cont_next = pending_cont;
    fresh = 1'b1;
    code_ev = 1'b0;
    named_ev = 1'b0;
    cp = '0;
    acc_cat = {code_accum[14:0], in_byte[5:0]};
    off = '0;
    esc_len = '0;
    esc_bytes = '0;

    if (pending_cont != 2'd0 && !halted) begin
      if (in_byte[7:6] == 2'b10) begin
        fresh = 1'b0;
        pending_cont_next = 2'(pending_cont - 2'd1);
        if (pending_cont == 2'd1) begin
          code_ev = 1'b1;
          cp = acc_cat;
          code_accum_next = '0;
        end else begin
          code_accum_next = acc_cat;
        end
      end else begin
        // broken sequence: drop it and treat this byte as new
        pending_cont_next = '0;
        code_accum_next = '0;
      end
    end

    if (fresh) begin
      if (in_byte == 8'h00) begin
        seq.len = 4'd1;
        seq.done = 1'b1;
        seq.length = used_count;
        seq.base = (used_count < cap) ? used_count : 16'(cap - 16'd1);
        used_count_next = '0;
        halted_next = 1'b0;
        code_accum_next = '0;
        pending_cont_next = '0;
      end else if (!halted) begin
        if (named != 8'h00) begin
          named_ev = 1'b1;
        end else if (in_byte < 8'h20) begin
          code_ev = 1'b1;
          cp = {13'b0, in_byte};
        end else if (in_byte < 8'h80) begin
          if ({2'b0, used_count} + 18'd2 > {2'b0, cap}) begin
            halted_next = 1'b1;
          end else begin
            seq.len = 4'd1;
            seq.bytes[0] = in_byte;
            seq.base = used_count;
            used_count_next = 16'(used_count + 16'd1);
          end
        end else if (in_byte[7:5] == 3'b110) begin
          code_accum_next = {16'b0, in_byte[4:0]};
          pending_cont_next = 2'd1;
        end else if (in_byte[7:4] == 4'b1110) begin
          code_accum_next = {17'b0, in_byte[3:0]};
          pending_cont_next = 2'd2;
        end else if (in_byte[7:3] == 5'b11110) begin
          code_accum_next = {18'b0, in_byte[2:0]};
          pending_cont_next = 2'd3;
        end
      end
    end

    if (named_ev) begin
      esc_len = 4'd2;
      esc_bytes[0] = CH_BSLASH;
      esc_bytes[1] = named;
    end else if (code_ev && cp <= CP_LIMIT && !(cp >= SURR_LO && cp <= SURR_HI)) begin
      if (cp < CP_PLANE1) begin
        esc_len = 4'd6;
        esc_bytes[5:0] = u16_esc(cp[15:0]);
      end else begin
        // surrogate pair above the basic plane
        off = 20'(cp - CP_PLANE1);
        esc_len = 4'd12;
        esc_bytes[5:0] = u16_esc(16'(HI_BASE + {6'b0, off[19:10]}));
        esc_bytes[11:6] = u16_esc(16'(LO_BASE + {6'b0, off[9:0]}));
      end
    end

    // an escape is written whole with room for the terminator, or not at all
    if (esc_len != 4'd0 &&
        {2'b0, used_count} + 18'(esc_len) + 18'd1 <= {2'b0, cap}) begin
      seq.len = esc_len;
      seq.bytes = esc_bytes;
      seq.base = used_count;
      used_count_next = 16'(used_count + 16'(esc_len));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
      halted <= 1'b0;
      code_accum <= '0;
      pending_cont <= '0;
    end else if (take) begin
      used_count <= used_count_next;
      halted <= halted_next;
      code_accum <= code_accum_next;
      pending_cont <= pending_cont_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/jse_emit.sv =====
// output stage: sends the bytes of one decoded item, one result per cycle while m_tready is high
`timescale 1ns / 1ps
`default_nettype none
module jse_emit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire jse_pkg::seq_t seq,
  output logic               can_load,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [39:0]        m_tdata,   // out_byte, out_index, out_length
  output logic               m_tlast,
  output logic [0:0]         m_tuser    // string_done
);
  import jse_pkg::*;

  logic [SEQ_MAX-1:0][7:0] bytes;
  logic [3:0]  remain;
  logic [15:0] index;
  logic        done;
  logic [15:0] length;
  logic        pop;

  assign m_tvalid = (remain != 4'd0);
  assign m_tlast = (remain == 4'd1);
  assign pop = m_tvalid && m_tready;
  assign can_load = !m_tvalid || (m_tlast && m_tready);
  assign m_tdata = {length, index, bytes[0]};
  assign m_tuser = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= '0;
    end else if (load) begin
      remain <= seq.len;
      bytes <= seq.bytes;
      index <= seq.base;
      done <= seq.done;
      length <= seq.length;
    end else if (pop) begin
      remain <= 4'(remain - 4'd1);
      bytes <= bytes >> 8;
      index <= 16'(index + 16'd1);
    end
  end

endmodule
`default_nettype wire

// ===== design/jse_checker.sv =====
// port-level checker of the json string escaper, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module jse_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic        m_tlast,
  input wire logic [0:0]  m_tuser
);

  // a stalled result holds
  `ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed under stall")
  // the terminator always closes its item
  `ASSERT_SAME(a_done_last, clk, rst, m_tvalid && m_tuser[0], m_tlast, "terminator not last")
  // length field only on the terminator
  `ASSERT_SAME(a_len_zero, clk, rst, m_tvalid && !m_tuser[0], m_tdata[39:24] == 16'd0, "length on non-terminator")
  // bytes of one escape follow back to back at rising positions
  `ASSERT_NEXT(a_index_step, clk, rst, m_tvalid && m_tready && !m_tlast, m_tvalid && m_tdata[23:8] == 16'($past(m_tdata[23:8]) + 16'd1), "escape bytes not contiguous")
  // terminator never lands beyond the written length
  `ASSERT_SAME(a_term_pos, clk, rst, m_tvalid && m_tuser[0], m_tdata[23:8] <= m_tdata[39:24], "terminator past length")

endmodule

bind json_string_escaper_utf8 jse_checker u_jse_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
`default_nettype wire
